// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
// ASSERT_HOLDS checks a property on every rising clock edge outside reset.
// ASSERT_NEVER checks that a condition is false on every rising clock edge outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: hdl/ivba_pkg.sv
package ivba_pkg;

	localparam int CHUNK_BITS = 8;
	localparam int BIT_W      = 3;
	localparam int ID_W       = 11;
	localparam int CFG_W      = 12;

	localparam logic [CHUNK_BITS-1:0] CHUNK_FULL = 8'hFF;

	// Source of the result that is loaded into the response register.
	localparam logic [1:0] RSP_FAIL  = 2'd0;
	localparam logic [1:0] RSP_ALLOC = 2'd1;
	localparam logic [1:0] RSP_FREE  = 2'd2;

	typedef struct packed {
		logic            req_type;
		logic [ID_W-1:0] vector_id;
	} ivba_req_t;

	typedef struct packed {
		logic            ok;
		logic [ID_W-1:0] granted_id;
	} ivba_rsp_t;

	typedef struct packed {
		logic       clr_wr;
		logic       load_req;
		logic       scan_start;
		logic       scan_step;
		logic       free_rd;
		logic       free_wr;
		logic       alloc_wr;
		logic       rsp_load;
		logic [1:0] rsp_sel;
	} ivba_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic req_free;
		logic free_in_range;
		logic hit;
		logic scan_end;
	} ivba_status_t;

endpackage

// File: hdl/ivba_datapath.sv
`include "assert_macros.svh"

module ivba_datapath #(
	parameter int MAX_VECTORS = 2048
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wr,
	input  logic [ivba_pkg::CFG_W-1:0]              cfg_data,
	input  ivba_pkg::ivba_req_t                     req_data,
	input  ivba_pkg::ivba_cmd_t                     cmd,
	output ivba_pkg::ivba_status_t                  status,
	output ivba_pkg::ivba_rsp_t                     rsp_data
);

	localparam int NUM_CHUNKS = (MAX_VECTORS + ivba_pkg::CHUNK_BITS - 1) / ivba_pkg::CHUNK_BITS;
	localparam int CHUNK_AW   = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
	localparam int CHUNK_CW   = $clog2(NUM_CHUNKS + 1);
	localparam int CNT_W      = $clog2(MAX_VECTORS + 1);
	localparam int ID_FW      = CHUNK_AW + ivba_pkg::BIT_W;
	localparam int MAX_A      = (CNT_W > ID_FW) ? CNT_W : ID_FW;
	localparam int MAX_B      = (ivba_pkg::CFG_W > ivba_pkg::ID_W) ? ivba_pkg::CFG_W
		: ivba_pkg::ID_W;
	localparam int CMP_W      = ((MAX_A > MAX_B) ? MAX_A : MAX_B) + 1;

	localparam int CB = ivba_pkg::CHUNK_BITS;

	// Lowest clear bit of a chunk that is known not to be full.
	function automatic logic [ivba_pkg::BIT_W-1:0] lowest_zero(input logic [CB-1:0] d);
		logic [ivba_pkg::BIT_W-1:0] pos;
		pos = '0;
		for (int i = CB - 1; i >= 0; i--) begin
			if (!d[i]) begin
				pos = ivba_pkg::BIT_W'(i);
			end
		end
		return pos;
	endfunction

	logic [CB-1:0]               mem [NUM_CHUNKS];
	logic [CB-1:0]               rd_data_q;
	logic [CHUNK_AW-1:0]         chunk_s1;
	logic                        vld_s1;
	logic [CHUNK_CW-1:0]         addr_q;
	logic [CHUNK_CW-1:0]         nchk_q;
	logic [CNT_W-1:0]            lim_q;
	ivba_pkg::ivba_req_t         req_q;
	ivba_pkg::ivba_rsp_t         rsp_q;

	logic [CNT_W-1:0]            lim_n;
	logic [CHUNK_CW-1:0]         nchk_n;
	logic                        scan_more;
	logic                        rd_en;
	logic [CHUNK_AW-1:0]         rd_addr;
	logic                        wr_en;
	logic [CHUNK_AW-1:0]         wr_addr;
	logic [CB-1:0]               wr_data;
	logic [CHUNK_AW-1:0]         vid_chunk;
	logic [ivba_pkg::BIT_W-1:0]  vid_bit;
	logic [ivba_pkg::BIT_W-1:0]  free_pos;
	logic [ID_FW-1:0]            alloc_id;
	logic                        alloc_ok;
	logic [CB-1:0]               vid_mask;
	logic [CB-1:0]               alloc_mask;

	// Saturate the vector count to the capacity and derive the chunk count to scan.
	assign lim_n  = (CMP_W'(cfg_data) > CMP_W'(MAX_VECTORS)) ? CNT_W'(MAX_VECTORS)
		: CNT_W'(cfg_data);
	assign nchk_n = CHUNK_CW'((CMP_W'(lim_n) + CMP_W'(CB - 1)) >> ivba_pkg::BIT_W);

	assign vid_chunk  = CHUNK_AW'(req_q.vector_id >> ivba_pkg::BIT_W);
	assign vid_bit    = req_q.vector_id[ivba_pkg::BIT_W-1:0];
	assign vid_mask   = CB'(1) << vid_bit;
	assign free_pos   = lowest_zero(rd_data_q);
	assign alloc_mask = CB'(1) << free_pos;
	assign alloc_id   = {chunk_s1, free_pos};
	assign alloc_ok   = CMP_W'(alloc_id) < CMP_W'(lim_q);
	assign scan_more  = addr_q < nchk_q;

	assign status.clr_last      = addr_q == CHUNK_CW'(NUM_CHUNKS - 1);
	assign status.req_free      = req_q.req_type;
	assign status.free_in_range = CMP_W'(req_q.vector_id) < CMP_W'(lim_q);
	assign status.hit           = vld_s1 && (rd_data_q != ivba_pkg::CHUNK_FULL);
	assign status.scan_end      = !vld_s1 && !scan_more;

	assign rd_en   = cmd.free_rd || (cmd.scan_step && scan_more);
	assign rd_addr = cmd.free_rd ? vid_chunk : addr_q[CHUNK_AW-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q[CHUNK_AW-1:0];
		wr_data = '0;
		priority if (cmd.clr_wr) begin
			wr_en = 1'b1;
		end else if (cmd.alloc_wr) begin
			wr_en   = alloc_ok;
			wr_addr = chunk_s1;
			wr_data = rd_data_q | alloc_mask;
		end else if (cmd.free_wr) begin
			wr_en   = 1'b1;
			wr_addr = vid_chunk;
			wr_data = rd_data_q & ~vid_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (cmd.scan_step && scan_more) begin
			chunk_s1 <= addr_q[CHUNK_AW-1:0];
		end
		if (cmd.load_req) begin
			req_q <= req_data;
		end
		if (cmd.rsp_load) begin
			unique case (cmd.rsp_sel)
				ivba_pkg::RSP_ALLOC: begin
					rsp_q.ok         <= alloc_ok;
					rsp_q.granted_id <= alloc_ok ? ivba_pkg::ID_W'(alloc_id) : '0;
				end
				ivba_pkg::RSP_FREE: begin
					rsp_q.ok         <= |(rd_data_q & vid_mask);
					rsp_q.granted_id <= '0;
				end
				default: begin
					rsp_q.ok         <= 1'b0;
					rsp_q.granted_id <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			vld_s1 <= 1'b0;
			lim_q  <= '0;
			nchk_q <= '0;
		end else begin
			if (cfg_wr) begin
				lim_q  <= lim_n;
				nchk_q <= nchk_n;
			end
			priority if (cmd.scan_start) begin
				addr_q <= '0;
				vld_s1 <= 1'b0;
			end else if (cmd.clr_wr) begin
				addr_q <= addr_q + CHUNK_CW'(1);
			end else if (cmd.scan_step) begin
				vld_s1 <= scan_more;
				if (scan_more) begin
					addr_q <= addr_q + CHUNK_CW'(1);
				end
			end
		end
	end

	assign rsp_data = rsp_q;

	`ASSERT_HOLDS(a_grant_within_scan, clk, arst_n,
		(cmd.alloc_wr && alloc_ok) |-> (CHUNK_CW'(chunk_s1) < nchk_q))
	`ASSERT_NEVER(a_clear_vs_read, clk, arst_n, cmd.clr_wr && rd_en)

endmodule

// File: hdl/ivba_ctrl.sv
`include "assert_macros.svh"

module ivba_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	input  ivba_pkg::ivba_status_t status,
	output ivba_pkg::ivba_cmd_t    cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_FREE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_n;
	logic       rsp_valid_q;
	logic       rsp_free;

	// The response register can take a new result when empty or emptying now.
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.load_req = req_valid;
				if (req_valid) begin
					state_n = ST_START;
				end
			end
			ST_START: begin
				if (rsp_free) begin
					if (!status.req_free) begin
						cmd.scan_start = 1'b1;
						state_n        = ST_SCAN;
					end else if (status.free_in_range) begin
						cmd.free_rd = 1'b1;
						state_n     = ST_FREE;
					end else begin
						cmd.rsp_load = 1'b1;
						cmd.rsp_sel  = ivba_pkg::RSP_FAIL;
						state_n      = ST_IDLE;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.hit) begin
					cmd.alloc_wr = 1'b1;
					cmd.rsp_load = 1'b1;
					cmd.rsp_sel  = ivba_pkg::RSP_ALLOC;
					state_n      = ST_IDLE;
				end else if (status.scan_end) begin
					cmd.rsp_load = 1'b1;
					cmd.rsp_sel  = ivba_pkg::RSP_FAIL;
					state_n      = ST_IDLE;
				end
			end
			ST_FREE: begin
				cmd.free_wr  = 1'b1;
				cmd.rsp_load = 1'b1;
				cmd.rsp_sel  = ivba_pkg::RSP_FREE;
				state_n      = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_HOLDS(a_load_into_free_slot, clk, arst_n, cmd.rsp_load |-> rsp_free)
	`ASSERT_HOLDS(a_load_ends_request, clk, arst_n,
		cmd.rsp_load |=> (state_q == ST_IDLE && rsp_valid_q))
	`ASSERT_HOLDS(a_clear_runs_to_end, clk, arst_n,
		(state_q == ST_CLEAR && !status.clr_last) |=> state_q == ST_CLEAR)

endmodule

// File: hdl/interrupt_vector_bitmap_allocator.sv
// Interrupt vector allocator. The block keeps one "in use" bit for each of
// MAX_VECTORS vector numbers, held as 8-bit chunks in an on-chip memory. An
// allocate transaction (req_type 0) grants the lowest free vector below the
// configured vector_count, marks it used and returns it with ok set; with no
// free vector below the count it returns ok 0 and granted_id 0. A free
// transaction (req_type 1) clears the bit of vector_id when that number is below
// the count and returns ok 1 only if the vector was in use; granted_id is 0. A
// count written above MAX_VECTORS acts as MAX_VECTORS, and lowering the count
// leaves bits above it untouched. One request is worked on at a time, and its
// handling is set by the single memory port: a free reads the chunk of
// vector_id and writes it back (no memory access when vector_id is at or
// above the count), and an allocate reads chunks from the lowest upward until
// it finds one that is not full or passes the last chunk below the count. The
// next request can be accepted in the cycle after a result is produced, even
// while that result is still stalled at the output; that request then waits
// in its start state until the output register frees up, so output stalls
// lengthen its handling. After reset the block clears the memory, one chunk
// per cycle, and holds req_stall high for that time; vector_count writes are
// taken at any time and are expected only while no request is outstanding.

module interrupt_vector_bitmap_allocator #(
	parameter int MAX_VECTORS = 2048
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ivba_pkg::CFG_W-1:0] cfg_data,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  ivba_pkg::ivba_req_t        req_data,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output ivba_pkg::ivba_rsp_t        rsp_data
);

	ivba_pkg::ivba_cmd_t    cmd;
	ivba_pkg::ivba_status_t status;

	// The count register is a plain register write, so the port never pushes back.
	assign cfg_ready = 1'b1;

	ivba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	ivba_datapath #(
		.MAX_VECTORS (MAX_VECTORS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.req_data (req_data),
		.cmd      (cmd),
		.status   (status),
		.rsp_data (rsp_data)
	);

endmodule

// File: tb/sv/interrupt_vector_bitmap_allocator_tb.sv
module interrupt_vector_bitmap_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_VECTORS = 2048;

	// Request kinds carried in req_type.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// Ways the response side may hold off the block.
	localparam int STALL_NONE    = 0;
	localparam int STALL_RANDOM  = 1;
	localparam int STALL_PATTERN = 2;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [ivba_pkg::CFG_W-1:0] cfg_data;
	logic                       req_valid;
	logic                       req_stall;
	ivba_pkg::ivba_req_t        req_data;
	logic                       rsp_valid;
	logic                       rsp_stall;
	ivba_pkg::ivba_rsp_t        rsp_data;

	interrupt_vector_bitmap_allocator #(
		.MAX_VECTORS(MAX_VECTORS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	// 10 ns clock, low half first.
	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Shadow copy of the allocator: one "in use" flag per vector and the
	// vector_count register as last written.
	logic [MAX_VECTORS-1:0]     vec_used;
	logic [ivba_pkg::CFG_W-1:0] vec_count;

	// Outcomes predicted for accepted requests, oldest first.
	ivba_pkg::ivba_rsp_t outcome_q[$];

	int fail_count  = 0;
	int req_total   = 0;
	int rsp_total   = 0;
	int grant_total = 0;
	int cfg_total   = 0;

	// Sender pacing: when gaps_on is set, requests go out in bursts of
	// burst_left + 1 back-to-back transactions separated by idle cycles.
	bit gaps_on    = 1'b0;
	int burst_left = 0;

	int stall_mode = STALL_NONE;
	int stall_tick = 0;

	// The count as the block uses it: values above capacity saturate.
	function automatic int live_count();
		return (int'(vec_count) > MAX_VECTORS) ? MAX_VECTORS : int'(vec_count);
	endfunction

	// Works out the response to one request and applies its effect on the
	// shadow bitmap. An allocate takes the lowest clear flag below the count;
	// a free clears the flag of an in-range vector and reports its old value.
	function automatic ivba_pkg::ivba_rsp_t predict_outcome(ivba_pkg::ivba_req_t r);
		ivba_pkg::ivba_rsp_t p;
		int                  n;
		p = '0;
		n = live_count();
		if (r.req_type == REQ_ALLOC) begin
			for (int i = 0; i < n; i++) begin
				if (!vec_used[i]) begin
					vec_used[i]  = 1'b1;
					p.ok         = 1'b1;
					p.granted_id = ivba_pkg::ID_W'(i);
					break;
				end
			end
		end else if (int'(r.vector_id) < n) begin
			p.ok                 = vec_used[r.vector_id];
			vec_used[r.vector_id] = 1'b0;
		end
		return p;
	endfunction

	// Response side stall generator. Besides random stalls there is a fixed
	// rhythm so that held results line up with every stage of the scan.
	always @(negedge clk) begin
		stall_tick <= stall_tick + 1;
		case (stall_mode)
			STALL_NONE: begin
				rsp_stall <= 1'b0;
			end
			STALL_RANDOM: begin
				rsp_stall <= ($urandom_range(0, 2) == 0);
			end
			default: begin
				rsp_stall <= ((stall_tick % 11) < 4);
			end
		endcase
	end

	// Every response transaction is matched against the oldest prediction.
	always @(posedge clk) begin
		ivba_pkg::ivba_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_total++;
			if (outcome_q.size() == 0) begin
				$error("response with no request outstanding: ok %0d granted_id %0d",
					rsp_data.ok, rsp_data.granted_id);
				fail_count++;
			end else begin
				want = outcome_q.pop_front();
				if (want.ok) begin
					grant_total++;
				end
				if (rsp_data.ok !== want.ok) begin
					$error("ok mismatch: expected %0d actual %0d", want.ok, rsp_data.ok);
					fail_count++;
				end
				if (rsp_data.granted_id !== want.granted_id) begin
					$error("granted_id mismatch: expected %0d actual %0d",
						want.granted_id, rsp_data.granted_id);
					fail_count++;
				end
			end
		end
	end

	// Sends one request transaction. Called at a falling edge and returns at
	// a falling edge. The payload is held until the block takes it, and the
	// prediction is made at the edge of acceptance so that it sees the bitmap
	// exactly as the block does.
	task automatic send_req(input logic kind, input logic [ivba_pkg::ID_W-1:0] id);
		ivba_pkg::ivba_req_t r;
		r.req_type  = kind;
		r.vector_id = id;
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (req_stall);
		outcome_q.push_back(predict_outcome(r));
		req_total++;
		@(negedge clk);
		if (gaps_on) begin
			if (burst_left == 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = $urandom_range(0, 7);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Stops sending and waits until every predicted response has come back.
	task automatic drain();
		req_valid <= 1'b0;
		while (outcome_q.size() != 0) @(negedge clk);
	endtask

	// Writes vector_count while no request is outstanding.
	task automatic set_vector_count(input logic [ivba_pkg::CFG_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		vec_count = value;
		cfg_total++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Straight after reset the count is zero, so nothing can be granted or
	// freed, not even the top vector number.
	task automatic test_zero_count();
		send_req(REQ_ALLOC, '0);
		send_req(REQ_FREE, '0);
		send_req(REQ_FREE, '1);
	endtask

	// A count of nine spans two chunks: nine grants in order, then failure,
	// then frees of a used vector, of the same vector again, and of the first
	// number past the count.
	task automatic test_fill_past_chunk();
		set_vector_count(ivba_pkg::CFG_W'(9));
		repeat (10) send_req(REQ_ALLOC, ivba_pkg::ID_W'($urandom_range(0, 2047)));
		send_req(REQ_FREE, ivba_pkg::ID_W'(8));
		send_req(REQ_FREE, ivba_pkg::ID_W'(8));
		send_req(REQ_FREE, ivba_pkg::ID_W'(9));
	endtask

	// Lowering the count below vectors in use hides them; raising it again
	// brings them back unchanged.
	task automatic test_count_shrink();
		set_vector_count(ivba_pkg::CFG_W'(3));
		send_req(REQ_ALLOC, '0);
		send_req(REQ_FREE, ivba_pkg::ID_W'(5));
		set_vector_count(ivba_pkg::CFG_W'(9));
		send_req(REQ_FREE, ivba_pkg::ID_W'(5));
		send_req(REQ_ALLOC, '1);
	endtask

	// Counts above capacity act as full capacity, so the top vector number
	// is in range. Alternating bit patterns toggle every bit of vector_id.
	task automatic test_count_saturation();
		set_vector_count('1);
		send_req(REQ_ALLOC, '0);
		send_req(REQ_FREE, '1);
		send_req(REQ_FREE, ivba_pkg::ID_W'(8));
		set_vector_count(ivba_pkg::CFG_W'(MAX_VECTORS + 1));
		send_req(REQ_FREE, '1);
		set_vector_count(ivba_pkg::CFG_W'(MAX_VECTORS));
		send_req(REQ_ALLOC, '0);
		send_req(REQ_FREE, ivba_pkg::ID_W'(11'h555));
		send_req(REQ_FREE, ivba_pkg::ID_W'(11'h2AA));
	endtask

	// Random phases. Each picks a count, mostly small so that the bitmap
	// fills up and failing allocates and real frees are common, and sometimes
	// zero or at or past capacity. Frees mostly target numbers that may be in
	// use, with some at the count boundary and some anywhere.
	task automatic test_random_traffic();
		int n;
		int pick;
		int hi;
		for (int phase = 0; phase < 12; phase++) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				set_vector_count('0);
			end else if (pick == 1) begin
				case ($urandom_range(0, 2))
					0: set_vector_count(ivba_pkg::CFG_W'(MAX_VECTORS));
					1: set_vector_count('1);
					default: set_vector_count(ivba_pkg::CFG_W'($urandom_range(0, 4095)));
				endcase
			end else begin
				set_vector_count(ivba_pkg::CFG_W'($urandom_range(1, 48)));
			end
			stall_mode = phase % 3;
			gaps_on    = (phase % 4) != 0;
			n  = live_count();
			hi = (n > 64) ? 63 : n - 1;
			repeat (45) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					send_req(REQ_ALLOC, ivba_pkg::ID_W'($urandom_range(0, 2047)));
				end else if (pick < 82 && n > 0) begin
					send_req(REQ_FREE, ivba_pkg::ID_W'($urandom_range(0, hi)));
				end else if (pick < 90 && n > 0 && n < MAX_VECTORS) begin
					send_req(REQ_FREE, ivba_pkg::ID_W'(n + $urandom_range(0, 1)));
				end else begin
					send_req(REQ_FREE, ivba_pkg::ID_W'($urandom_range(0, 2047)));
				end
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		req_valid = 1'b0;
		req_data  = '0;
		rsp_stall = 1'b0;
		vec_used  = '0;
		vec_count = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The block clears its memory after reset and stalls requests until
		// it is done; the first send simply waits that out.
		test_zero_count();
		test_fill_past_chunk();
		test_count_shrink();
		test_count_saturation();
		test_random_traffic();

		drain();
		stall_mode = STALL_NONE;
		// Give any stray response time to show up.
		repeat (MAX_VECTORS / ivba_pkg::CHUNK_BITS + 8) @(negedge clk);

		$display("Ran %0d allocate/free requests (%0d granted or freed) over %0d count settings.",
			req_total, grant_total, cfg_total);
		$display("Checked %0d responses, %0d mismatches.", rsp_total, fail_count);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#8ms;
		$display("Timed out with %0d responses outstanding.", outcome_q.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
